// ----- rtl/core/ubsd_pkg.sv -----
// Shared types, constants and byte classification for the UTF-8 BMP decoder.
// No dependencies; ubsd_step, ubsd_out_reg, the top and the testbench import it.
package ubsd_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 16;
  localparam int unsigned FIELD_W            = 16;
  localparam logic [15:0] MAX_CHARS_RESET    = 16'hFFFF;

  // Lead and continuation byte patterns
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_CODE    = 8'hE0;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;
  localparam logic [7:0] HIGH_BIT      = 8'h80;
  localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
  localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
  localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef enum logic [1:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_CONT
  } byte_class_t;

  // Sequence state carried between bytes
  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] accumulator;
  } seq_state_t;

  // One result transaction
  typedef struct packed {
    logic        char_valid;
    logic [15:0] code_point;
    logic        malformed;
    logic        refused;
    logic        end_of_string;
    logic [15:0] bytes_consumed;
  } result_t;

  // Bytes 0xF0-0xFF fall through to the continuation class
  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t cls;
    if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      cls = CLS_LEAD3;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      cls = CLS_LEAD2;
    end else if ((b & HIGH_BIT) != 8'h00) begin
      cls = CLS_CONT;
    end else begin
      cls = CLS_ASCII;
    end
    return cls;
  endfunction

endpackage

// ----- rtl/core/ubsd_byte_if.sv -----
// Input channel: one UTF-8 byte per transaction with valid/ready handshake.
// Depends on nothing but the language; widths are fixed by the byte format.
interface ubsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/ubsd_char_if.sv -----
// Output channel: one decode result per transaction with valid/ready handshake.
// Depends on nothing but the language; widths are fixed by the result format.
interface ubsd_char_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [15:0] code_point;
  logic        malformed;
  logic        refused;
  logic        end_of_string;
  logic [15:0] bytes_consumed;

  modport source (output valid, output char_valid, output code_point, output malformed,
                  output refused, output end_of_string, output bytes_consumed,
                  input ready);
  modport sink   (input valid, input char_valid, input code_point, input malformed,
                  input refused, input end_of_string, input bytes_consumed,
                  output ready);
endinterface

// ----- rtl/core/ubsd_step.sv -----
// Per-byte decode logic: next sequence state, counters and result for one byte.
// Depends on ubsd_pkg.
module ubsd_step #(
  parameter int unsigned CNT_W = ubsd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [15:0]          max_chars,
  input  ubsd_pkg::seq_state_t seq,
  input  logic [CNT_W-1:0]     emitted,
  input  logic [CNT_W-1:0]     consumed,
  output ubsd_pkg::seq_state_t seq_next,
  output logic [CNT_W-1:0]     emitted_next,
  output logic [CNT_W-1:0]     consumed_next,
  output ubsd_pkg::result_t    res
);
  import ubsd_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  byte_class_t      cls;
  seq_state_t       seq_upd;
  logic [CNT_W-1:0] emitted_upd;
  logic [CNT_W-1:0] consumed_upd;
  logic             limit_hit;
  logic             emit;
  logic             bad;
  logic [15:0]      cp;
  logic [15:0]      acc_shift;

  assign cls       = classify(data_byte);
  assign limit_hit = (16'(emitted) >= max_chars);
  assign acc_shift = {seq.accumulator[9:0], data_byte[5:0]};

  always_comb begin
    seq_upd = seq;
    emit    = 1'b0;
    bad     = 1'b0;
    cp      = '0;
    unique case (cls)
      CLS_LEAD3: begin
        bad                 = (seq.pending != PEND_NONE);
        seq_upd.accumulator = 16'(data_byte & LEAD3_PAYLOAD);
        seq_upd.pending     = PEND_TWO;
      end
      CLS_LEAD2: begin
        bad                 = (seq.pending != PEND_NONE);
        seq_upd.accumulator = 16'(data_byte & LEAD2_PAYLOAD);
        seq_upd.pending     = PEND_ONE;
      end
      CLS_CONT: begin
        if (seq.pending != PEND_NONE) begin
          seq_upd.accumulator = acc_shift;
          seq_upd.pending     = seq.pending - 2'd1;
          if (seq.pending == PEND_ONE) begin
            emit = 1'b1;
            cp   = acc_shift;
          end
        end else begin
          // stray continuation: drop it
          bad = 1'b1;
        end
      end
      CLS_ASCII: begin
        bad             = (seq.pending != PEND_NONE);
        seq_upd.pending = PEND_NONE;
        emit            = 1'b1;
        cp              = 16'(data_byte);
      end
      default: begin
        seq_upd = seq;
      end
    endcase
  end

  assign consumed_upd = (consumed == CNT_MAX) ? consumed : consumed + 1'b1;
  assign emitted_upd  = (emit && emitted != CNT_MAX) ? emitted + 1'b1 : emitted;

  always_comb begin
    res.end_of_string = last_byte;
    if (limit_hit) begin
      res.char_valid     = 1'b0;
      res.code_point     = '0;
      res.malformed      = 1'b0;
      res.refused        = 1'b1;
      res.bytes_consumed = 16'(consumed);
    end else begin
      res.char_valid     = emit;
      res.code_point     = cp;
      res.malformed      = bad;
      res.refused        = 1'b0;
      res.bytes_consumed = 16'(consumed_upd);
    end

    // last byte of the string clears everything after the result is formed
    if (last_byte) begin
      seq_next      = '0;
      emitted_next  = '0;
      consumed_next = '0;
    end else if (limit_hit) begin
      seq_next      = seq;
      emitted_next  = emitted;
      consumed_next = consumed;
    end else begin
      seq_next      = seq_upd;
      emitted_next  = emitted_upd;
      consumed_next = consumed_upd;
    end
  end

endmodule

// ----- rtl/core/ubsd_out_reg.sv -----
// Result register: holds one result transaction and frees itself as it leaves.
// Depends on ubsd_pkg and ubsd_char_if.
module ubsd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  ubsd_pkg::result_t   res,
  ubsd_char_if.source         char_ch
);
  import ubsd_pkg::*;

  logic    valid;
  result_t data;

  // free when empty or when the held result leaves this cycle
  assign load_ready = !valid || char_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= res;
    end
  end

  assign char_ch.valid          = valid;
  assign char_ch.char_valid     = data.char_valid;
  assign char_ch.code_point     = data.code_point;
  assign char_ch.malformed      = data.malformed;
  assign char_ch.refused        = data.refused;
  assign char_ch.end_of_string  = data.end_of_string;
  assign char_ch.bytes_consumed = data.bytes_consumed;

endmodule

// ----- rtl/core/utf8_bmp_stream_decoder.sv -----
// Top level of the UTF-8 to 16-bit code point stream decoder.
// Depends on ubsd_pkg, ubsd_byte_if, ubsd_char_if, ubsd_step and ubsd_out_reg.
//
//   channel   | direction | transaction carries
//   ----------+-----------+--------------------------------------------------
//   byte_ch   | in        | data_byte, last_byte
//   char_ch   | out       | char_valid, code_point, malformed, refused,
//             |           | end_of_string, bytes_consumed
//   cfg       | in        | cfg_we / cfg_wdata write max_chars
//
// One byte per cycle unless char_ch stalls: a byte is decoded in the cycle it
// is accepted and its result sits in the output register from the cycle after.
// The output register alone sets the pace; byte_ch.ready stays high while that
// register is empty or its result is taken in the same cycle.
// Reset clears the sequence state and both counts and sets max_chars to 65535.
// A stall on char_ch holds the result and drops byte_ch.ready until it clears.
module utf8_bmp_stream_decoder #(
  parameter int unsigned COUNT_BITS = ubsd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ubsd_byte_if.sink     byte_ch,
  ubsd_char_if.source   char_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);
  import ubsd_pkg::*;

  // counts saturate at the smaller of their own range and the 16-bit field
  localparam int unsigned CNT_W = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;

  logic [15:0]      max_chars;
  seq_state_t       seq;
  seq_state_t       seq_next;
  logic [CNT_W-1:0] emitted_count;
  logic [CNT_W-1:0] emitted_count_next;
  logic [CNT_W-1:0] consumed_count;
  logic [CNT_W-1:0] consumed_count_next;
  result_t          res;
  logic             accept;

  // Configuration: one register, to be written by the user only while the stream is idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_we) begin
      max_chars <= cfg_wdata;
    end
  end

  // Decode the incoming byte against the current state
  ubsd_step #(
    .CNT_W (CNT_W)
  ) u_step (
    .data_byte     (byte_ch.data_byte),
    .last_byte     (byte_ch.last_byte),
    .max_chars     (max_chars),
    .seq           (seq),
    .emitted       (emitted_count),
    .consumed      (consumed_count),
    .seq_next      (seq_next),
    .emitted_next  (emitted_count_next),
    .consumed_next (consumed_count_next),
    .res           (res)
  );

  assign accept = byte_ch.valid && byte_ch.ready;

  // Advance the sequence state and counts only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= '0;
      emitted_count  <= '0;
      consumed_count <= '0;
    end else if (accept) begin
      seq            <= seq_next;
      emitted_count  <= emitted_count_next;
      consumed_count <= consumed_count_next;
    end
  end

  // Hold the result until the sink takes it
  ubsd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (byte_ch.valid),
    .load_ready (byte_ch.ready),
    .res        (res),
    .char_ch    (char_ch)
  );

endmodule

// ----- rtl/core/ubsd_checker.sv -----
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on utf8_bmp_stream_decoder and its char_ch port.
module ubsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        char_valid,
  input logic [15:0] code_point,
  input logic        malformed,
  input logic        refused
);

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(code_point) && $stable(char_valid))
    else $error("stalled result changed");

  // a refused byte raises no other flag and carries no code point
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    valid && refused |-> !char_valid && !malformed && code_point == 16'd0)
    else $error("refused result carries other flags");

  // no code point without a character
  a_cp_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !char_valid |-> code_point == 16'd0)
    else $error("code point set without char_valid");

endmodule

bind utf8_bmp_stream_decoder ubsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (char_ch.valid),
  .ready      (char_ch.ready),
  .char_valid (char_ch.char_valid),
  .code_point (char_ch.code_point),
  .malformed  (char_ch.malformed),
  .refused    (char_ch.refused)
);

// ----- sim/utf8_bmp_stream_decoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for utf8_bmp_stream_decoder: directed and random UTF-8 text.
// Depends on ubsd_pkg, ubsd_byte_if, ubsd_char_if and the decoder RTL.
module utf8_bmp_stream_decoder_tb;
  import ubsd_pkg::*;

  localparam int unsigned SEND_GAP_MAX    = 3;
  localparam int unsigned STALL_MAX       = 3;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;  // 2^COUNT_BITS - 1 at the default width
  localparam logic [15:0] NO_LIMIT        = MAX_CHARS_RESET;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ubsd_byte_if byte_ch ();
  ubsd_char_if char_ch ();

  utf8_bmp_stream_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .char_ch   (char_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder state as the testbench tracks it, plus the programmed limit
  logic [1:0]  seq_pending;
  logic [15:0] seq_acc;
  logic [15:0] chars_out;
  logic [15:0] bytes_in;
  logic [15:0] char_limit;

  result_t     decoded_q[$];   // results owed by the block, oldest first
  logic [7:0]  text_q[$];      // string being sent

  bit          sender_gaps_on;
  bit          sink_stalls_on;
  int unsigned hold_request;
  int unsigned holds_done;
  int unsigned bytes_sent;
  int unsigned errors;
  int unsigned n_results;
  int unsigned n_chars;
  int unsigned n_malformed;
  int unsigned n_refused;
  int unsigned n_strings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sat_bump(input logic [15:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 16'd1;
  endfunction

  // Work out the result of one byte and advance the tracked state.
  function automatic result_t decode_byte(input logic [7:0] b, input logic last);
    result_t     r;
    byte_class_t cls;
    r = '0;
    r.end_of_string = last;
    if (chars_out >= char_limit) begin
      // Limit reached: refuse the byte and leave every count where it is
      r.refused = 1'b1;
    end else begin
      bytes_in = sat_bump(bytes_in);
      // Bytes 0xF0-0xFF miss both lead patterns and land among continuations
      if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        cls = CLS_LEAD3;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        cls = CLS_LEAD2;
      end else if ((b & HIGH_BIT) != 8'h00) begin
        cls = CLS_CONT;
      end else begin
        cls = CLS_ASCII;
      end
      case (cls)
        CLS_LEAD3: begin
          r.malformed = (seq_pending != PEND_NONE);
          seq_acc     = {8'h00, b & LEAD3_PAYLOAD};
          seq_pending = PEND_TWO;
        end
        CLS_LEAD2: begin
          r.malformed = (seq_pending != PEND_NONE);
          seq_acc     = {8'h00, b & LEAD2_PAYLOAD};
          seq_pending = PEND_ONE;
        end
        CLS_CONT: begin
          if (seq_pending != PEND_NONE) begin
            seq_acc     = (seq_acc << 6) | {8'h00, b & CONT_PAYLOAD};
            seq_pending = seq_pending - 2'd1;
            if (seq_pending == PEND_NONE) begin
              r.char_valid = 1'b1;
              r.code_point = seq_acc;
            end
          end else begin
            // Stray continuation: drop it, though it still counts as consumed
            r.malformed = 1'b1;
          end
        end
        CLS_ASCII: begin
          r.malformed  = (seq_pending != PEND_NONE);
          seq_pending  = PEND_NONE;
          r.char_valid = 1'b1;
          r.code_point = {8'h00, b};
        end
      endcase
      if (r.char_valid) chars_out = sat_bump(chars_out);
    end
    r.bytes_consumed = bytes_in;
    // Last byte: report first, then clear everything but the limit
    if (last) begin
      seq_pending = PEND_NONE;
      seq_acc     = '0;
      chars_out   = '0;
      bytes_in    = '0;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Offer one byte, hold it until the block takes it, then log what it owes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = sender_gaps_on ? $urandom_range(0, SEND_GAP_MAX) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    decoded_q.push_back(decode_byte(b, last));
    bytes_sent++;
  endtask

  // Send text_q as one string, the final byte marked last.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_chars(input logic [15:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    char_limit = v;
  endtask

  task automatic test_ascii();
    text_q = '{8'h00, 8'h7F};
    send_text();
  endtask

  task automatic test_multibyte();
    // a common sign and the largest two-byte value, then three-byte extremes
    text_q = '{8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    send_text();
  endtask

  task automatic test_malformed();
    // stray continuation; lead over a pending pair; ASCII over a pending triple;
    // 0xF0 and 0xFF taken as continuations
    text_q = '{8'h80, 8'hC3, 8'hE2, 8'h82, 8'hAC, 8'hE2, 8'h41, 8'hE2, 8'hF0, 8'hFF};
    send_text();
    // string cut short inside a sequence: drop it quietly
    text_q = '{8'hE2, 8'h82};
    send_text();
  endtask

  task automatic test_char_limit();
    write_max_chars(16'd2);
    text_q = '{8'h41, 8'h42, 8'h43, 8'hC2, 8'hA9};
    send_text();
    text_q = '{8'h44};
    send_text();
    write_max_chars(16'd0);
    text_q = '{8'h45, 8'h80};
    send_text();
  endtask

  // Mostly well-formed strings with random content; some noise and cut tails.
  task automatic test_random_text(input int unsigned n_bytes, input logic [15:0] limit);
    int unsigned first;
    int unsigned n_chars_str;
    int unsigned pick;
    write_max_chars(limit);
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      if ($urandom_range(0, 5) == 0) sender_gaps_on = !sender_gaps_on;
      if ($urandom_range(0, 5) == 0) sink_stalls_on = !sink_stalls_on;
      text_q.delete();
      n_chars_str = $urandom_range(1, 10);
      repeat (n_chars_str) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 40) begin
          text_q.push_back(8'($urandom_range(0, 127)));
        end else if (pick < 70) begin
          text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
          text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
          text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end
      if (text_q.size() > 1 && $urandom_range(0, 7) == 0) void'(text_q.pop_back());
      send_text();
    end
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Hold the output off for a long stretch while bytes keep coming, then
  // pause the sender until the block has handed back everything; then finish the string.
  task automatic test_output_stall();
    sender_gaps_on = 1'b0;
    hold_request   = HOLD_OFF_CYCLES;
    repeat (24) send_byte(8'($urandom_range(0, 127)), 1'b0);
    drain_results();
    repeat (10) send_byte(8'($urandom_range(0, 127)), 1'b0);
    send_byte(8'h0A, 1'b1);
    sender_gaps_on = 1'b1;
  endtask

  // Receiver: draw a stall per transaction, or take a requested long hold-off.
  initial begin
    int unsigned stall;
    char_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
        holds_done++;
      end else begin
        stall = sink_stalls_on ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (stall != 0) begin
        char_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_ch.ready <= 1'b1;
      do @(posedge clk); while (char_ch.valid !== 1'b1);
    end
  end

  // Check every result transaction against the oldest owed result.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst === 1'b0 && char_ch.valid === 1'b1 && char_ch.ready === 1'b1) begin
      got.char_valid     = char_ch.char_valid;
      got.code_point     = char_ch.code_point;
      got.malformed      = char_ch.malformed;
      got.refused        = char_ch.refused;
      got.end_of_string  = char_ch.end_of_string;
      got.bytes_consumed = char_ch.bytes_consumed;
      n_results++;
      if (decoded_q.size() == 0) begin
        note_failure($sformatf("result with nothing owed: cp=%h cnt=%h",
                               got.code_point, got.bytes_consumed));
      end else begin
        want = decoded_q.pop_front();
        if (got.char_valid !== want.char_valid || got.code_point !== want.code_point ||
            got.malformed !== want.malformed || got.refused !== want.refused ||
            got.end_of_string !== want.end_of_string ||
            got.bytes_consumed !== want.bytes_consumed) begin
          note_failure($sformatf(
            "result %0d: expected cv=%b cp=%h mal=%b ref=%b eos=%b cnt=%h, got cv=%b cp=%h mal=%b ref=%b eos=%b cnt=%h",
            n_results, want.char_valid, want.code_point, want.malformed, want.refused,
            want.end_of_string, want.bytes_consumed, got.char_valid, got.code_point,
            got.malformed, got.refused, got.end_of_string, got.bytes_consumed));
        end
        if (want.char_valid) n_chars++;
        if (want.malformed) n_malformed++;
        if (want.refused) n_refused++;
        if (want.end_of_string) n_strings++;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
          (char_ch.valid === 1'b1 && char_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    seq_pending    = PEND_NONE;
    seq_acc        = '0;
    chars_out      = '0;
    bytes_in       = '0;
    char_limit     = NO_LIMIT;
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    hold_request   = 0;
    holds_done     = 0;
    bytes_sent     = 0;
    errors         = 0;
    n_results      = 0;
    n_chars        = 0;
    n_malformed    = 0;
    n_refused      = 0;
    n_strings      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases first, all but the limit test at the reset limit
    test_ascii();
    test_multibyte();
    test_malformed();
    test_char_limit();

    // Random text across several limits, the extremes among them
    test_random_text(300, NO_LIMIT);
    test_random_text(150, 16'($urandom_range(2, 8)));
    test_output_stall();
    test_random_text(120, 16'd1);
    test_random_text(40, 16'd0);
    test_random_text(250, 16'($urandom_range(9, 65534)));

    drain_results();
    if (decoded_q.size() != 0) note_failure("results still owed at the end");

    $display("Checked %0d byte transactions in %0d strings: %0d code points,",
             n_results, n_strings, n_chars);
    $display("%0d malformed, %0d refused; limits 0 to 65535, %0d long output hold-off(s).",
             n_malformed, n_refused, holds_done);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d check failures", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
